// ===== design/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the bitmap block allocator: field widths,
// status and register codes, controller states and the command and status
// groups between controller and datapath.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MAX_BLOCKS     = 1024;
    localparam int WORD_BITS      = 32;
    localparam int MAP_WORDS      = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int MIN_BLOCK_LOG2 = 3;
    localparam int MAX_BLOCK_LOG2 = 12;

    localparam int IDX_W    = 10;
    localparam int WIDX_W   = 5;
    localparam int BIT_W    = 5;
    localparam int WORDS_W  = 6;
    localparam int CNT_W    = 11;
    localparam int OFF_W    = 22;
    localparam int LEN_W    = 16;
    localparam int LOG2_W   = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0] CNT_MAX = 11'd2047;

    localparam logic [LOG2_W-1:0] BLOCK_LOG2_RESET = 4'd5;
    localparam logic [CNT_W-1:0]  BLOCKS_RESET     = 11'd1024;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_LOG2 = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE   = 1'd1;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_LARGE   = 3'd1,
        ST_NO_FREE     = 3'd2,
        ST_BAD_ADDR    = 3'd3,
        ST_DOUBLE_FREE = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_HINT,
        S_SCAN,
        S_FREE
    } fsm_state_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_CAND,
        RD_SCAN_START,
        RD_SCAN_NEXT
    } rd_sel_t;

    typedef enum logic [1:0] {
        COMMIT_NONE,
        COMMIT_ALLOC_HINT,
        COMMIT_ALLOC_SCAN,
        COMMIT_FREE
    } commit_t;

    typedef struct packed {
        logic    load;
        logic    setup;
        logic    clear_hint;
        rd_sel_t rd_sel;
        commit_t commit;
        logic    finish;
        status_t status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic func_free;
        logic too_large;
        logic bad_addr;
        logic hint_ok;
        logic no_words;
        logic cand_free;
        logic scan_found;
        logic scan_last;
    } dp_status_t;

endpackage

// ===== design/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// Generic simple dual-port ram: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// Controller of the bitmap block allocator: sequences the length and range
// checks, the hint probe, the word scan and the map update.
// ----------------------------------------------------------------------------
module bba_ctrl
    import bba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output logic       done,
    input  dp_status_t dp_sts,
    output ctrl_cmd_t  cmd
);

    fsm_state_t state_reg, state_next;
    logic       done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.finish;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (dp_sts.func_free)
                begin
                    state_next = dp_sts.bad_addr ? S_IDLE : S_FREE;
                end
                else if (dp_sts.too_large)
                begin
                    state_next = S_IDLE;
                end
                else if (dp_sts.hint_ok)
                begin
                    state_next = S_HINT;
                end
                else if (dp_sts.no_words)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_HINT:
            begin
                state_next = dp_sts.cand_free ? S_IDLE : S_SCAN;
            end
            S_SCAN:
            begin
                if (dp_sts.scan_found || dp_sts.scan_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FREE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd            = '0;
        cmd.rd_sel     = RD_NONE;
        cmd.commit     = COMMIT_NONE;
        cmd.status     = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
            end
            S_CHECK:
            begin
                cmd.setup = 1'b1;
                if (dp_sts.func_free)
                begin
                    if (dp_sts.bad_addr)
                    begin
                        cmd.finish = 1'b1;
                        cmd.status = ST_BAD_ADDR;
                    end
                    else
                    begin
                        cmd.rd_sel = RD_CAND;
                    end
                end
                else if (dp_sts.too_large)
                begin
                    cmd.finish = 1'b1;
                    cmd.status = ST_TOO_LARGE;
                end
                else
                begin
                    // any allocate past the length check uses up the hint
                    cmd.clear_hint = 1'b1;
                    if (dp_sts.hint_ok)
                    begin
                        cmd.rd_sel = RD_CAND;
                    end
                    else if (dp_sts.no_words)
                    begin
                        cmd.finish = 1'b1;
                        cmd.status = ST_NO_FREE;
                    end
                    else
                    begin
                        cmd.rd_sel = RD_SCAN_START;
                    end
                end
            end
            S_HINT:
            begin
                if (dp_sts.cand_free)
                begin
                    cmd.commit = COMMIT_ALLOC_HINT;
                    cmd.finish = 1'b1;
                    cmd.status = ST_OK;
                end
                else
                begin
                    cmd.rd_sel = RD_SCAN_START;
                end
            end
            S_SCAN:
            begin
                if (dp_sts.scan_found)
                begin
                    cmd.commit = COMMIT_ALLOC_SCAN;
                    cmd.finish = 1'b1;
                    cmd.status = ST_OK;
                end
                else if (dp_sts.scan_last)
                begin
                    cmd.finish = 1'b1;
                    cmd.status = ST_NO_FREE;
                end
                else
                begin
                    cmd.rd_sel = RD_SCAN_NEXT;
                end
            end
            S_FREE:
            begin
                cmd.finish = 1'b1;
                if (dp_sts.cand_free)
                begin
                    cmd.status = ST_DOUBLE_FREE;
                end
                else
                begin
                    cmd.commit = COMMIT_FREE;
                    cmd.status = ST_OK;
                end
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/bba_dpath.sv =====
// ----------------------------------------------------------------------------
// bba_dpath
// Datapath of the bitmap block allocator: configuration registers, used map
// ram with per-word valid bits, scan pointer, lowest-free-bit search,
// counters and result registers.
// ----------------------------------------------------------------------------
module bba_dpath
    import bba_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data,
    input  logic                 func,
    input  logic [LEN_W-1:0]     request_length,
    input  logic [OFF_W-1:0]     block_offset,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           dp_sts,
    output logic [2:0]           status,
    output logic [IDX_W-1:0]     block_index,
    output logic [OFF_W-1:0]     alloc_offset,
    output logic [CNT_W-1:0]     active_count,
    output logic [CNT_W-1:0]     peak_count
);

    // configuration
    logic [LOG2_W-1:0] bs_log2_reg;
    logic [CNT_W-1:0]  blocks_reg;

    // control state
    logic [IDX_W-1:0]     last_alloc_reg;
    logic [IDX_W-1:0]     hint_reg;
    logic [CNT_W-1:0]     active_reg, active_next;
    logic [CNT_W-1:0]     peak_reg, peak_next;
    logic [MAP_WORDS-1:0] valid_reg;
    logic [WIDX_W-1:0]    scan_w_reg, scan_w_next;
    logic [WIDX_W-1:0]    chk_cnt_reg;
    logic [WIDX_W-1:0]    rd_word_reg;
    logic                 rd_valid_reg;

    // latched item and results
    logic               func_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [OFF_W-1:0]   off_reg;
    logic [IDX_W-1:0]   cand_reg;
    logic [IDX_W-1:0]   cand_next;
    status_t            status_reg;
    logic [IDX_W-1:0]   index_reg;
    logic [OFF_W-1:0]   aoff_reg;

    logic [LOG2_W-1:0]  eff_log2;
    logic [CNT_W-1:0]   eff_count;
    logic [WORDS_W-1:0] words;
    logic [CNT_W:0]     words_sum;
    logic [LEN_W:0]     block_bytes;
    logic [OFF_W:0]     pool_end;
    logic [IDX_W-1:0]   free_idx;
    logic [WIDX_W-1:0]  start_w;

    logic                 rd_en;
    logic [WIDX_W-1:0]    rd_addr;
    logic [WORD_BITS-1:0] ram_q;
    logic [WORD_BITS-1:0] word_q;
    logic [WORD_BITS-1:0] elig_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic [BIT_W-1:0]     free_pos;
    logic [IDX_W-1:0]     found_idx;

    logic                 wr_en;
    logic [BIT_W-1:0]     wr_bit;
    logic [WORD_BITS-1:0] wr_onehot;
    logic [WORD_BITS-1:0] wr_data;
    logic [IDX_W-1:0]     res_idx;
    logic                 alloc_ok;

    function automatic logic [WIDX_W-1:0] next_word(input logic [WIDX_W-1:0] w,
                                                   input logic [WORDS_W-1:0] n);
        logic [WORDS_W-1:0] inc;
        inc = {1'b0, w} + WORDS_W'(1);
        return (inc == n) ? '0 : inc[WIDX_W-1:0];
    endfunction

    // effective configuration
    always_comb
    begin
        if (bs_log2_reg < LOG2_W'(MIN_BLOCK_LOG2))
            eff_log2 = LOG2_W'(MIN_BLOCK_LOG2);
        else if (bs_log2_reg > LOG2_W'(MAX_BLOCK_LOG2))
            eff_log2 = LOG2_W'(MAX_BLOCK_LOG2);
        else
            eff_log2 = bs_log2_reg;

        if (blocks_reg > CNT_W'(MAX_BLOCKS))
            eff_count = CNT_W'(MAX_BLOCKS);
        else
            eff_count = blocks_reg;
    end

    assign words_sum   = {1'b0, eff_count} + (CNT_W + 1)'(WORD_BITS - 1);
    assign words       = words_sum[BIT_W +: WORDS_W];
    assign block_bytes = (LEN_W + 1)'(1) << eff_log2;
    assign pool_end    = (OFF_W + 1)'(eff_count) << eff_log2;
    assign free_idx    = IDX_W'(off_reg >> eff_log2);
    assign start_w     = ({1'b0, last_alloc_reg[IDX_W-1 -: WIDX_W]} >= words) ?
                         '0 : last_alloc_reg[IDX_W-1 -: WIDX_W];

    // block probed by a free or by the hint
    assign cand_next   = (func_reg == FUNC_FREE) ? free_idx : hint_reg;

    // map ram read side
    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = '0;
        case (cmd.rd_sel)
            RD_CAND:       rd_addr = cand_next[IDX_W-1 -: WIDX_W];
            RD_SCAN_START: rd_addr = start_w;
            RD_SCAN_NEXT:  rd_addr = scan_w_reg;
            default:       rd_en   = 1'b0;
        endcase
    end

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (wr_en),
        .waddr (rd_word_reg),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // words never written since reset read as all free
    assign word_q = rd_valid_reg ? ram_q : '0;

    // only bits below the block count are eligible in a partial last word
    always_comb
    begin
        elig_mask = '1;
        if (({1'b0, rd_word_reg} + WORDS_W'(1) == words) && (eff_count[BIT_W-1:0] != '0))
        begin
            elig_mask = (WORD_BITS'(1) << eff_count[BIT_W-1:0]) - WORD_BITS'(1);
        end
    end

    assign free_bits = ~word_q & elig_mask;

    always_comb
    begin
        free_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (free_bits[i])
                free_pos = BIT_W'(i);
        end
    end

    assign found_idx = {rd_word_reg, free_pos};

    always_comb
    begin
        dp_sts            = '0;
        dp_sts.func_free  = (func_reg == FUNC_FREE);
        dp_sts.too_large  = ({1'b0, len_reg} > block_bytes);
        dp_sts.bad_addr   = ({1'b0, off_reg} >= pool_end);
        dp_sts.hint_ok    = (hint_reg != '0) && ({1'b0, hint_reg} < eff_count);
        dp_sts.no_words   = (words == '0);
        dp_sts.cand_free  = !word_q[cand_reg[BIT_W-1:0]];
        dp_sts.scan_found = (free_bits != '0);
        dp_sts.scan_last  = ({1'b0, chk_cnt_reg} + WORDS_W'(1) == words);
    end

    // map update
    assign wr_en     = (cmd.commit != COMMIT_NONE);
    assign wr_bit    = (cmd.commit == COMMIT_ALLOC_SCAN) ? free_pos : cand_reg[BIT_W-1:0];
    assign wr_onehot = WORD_BITS'(1) << wr_bit;
    assign wr_data   = (cmd.commit == COMMIT_FREE) ? (word_q & ~wr_onehot)
                                                   : (word_q | wr_onehot);

    assign alloc_ok = (cmd.commit == COMMIT_ALLOC_HINT) || (cmd.commit == COMMIT_ALLOC_SCAN);

    always_comb
    begin
        active_next = active_reg;
        peak_next   = peak_reg;
        if (alloc_ok)
        begin
            if (active_reg != CNT_MAX)
                active_next = active_reg + CNT_W'(1);
            if (peak_reg < active_next)
                peak_next = active_next;
        end
        else if (cmd.commit == COMMIT_FREE)
        begin
            if (active_reg != '0)
                active_next = active_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        res_idx = '0;
        if (cmd.commit == COMMIT_ALLOC_SCAN)
            res_idx = found_idx;
        else if ((cmd.status == ST_OK) || (cmd.status == ST_DOUBLE_FREE))
            res_idx = cand_reg;
    end

    always_comb
    begin
        scan_w_next = scan_w_reg;
        case (cmd.rd_sel)
            RD_SCAN_START: scan_w_next = next_word(start_w, words);
            RD_SCAN_NEXT:  scan_w_next = next_word(scan_w_reg, words);
            default:       scan_w_next = scan_w_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_log2_reg    <= BLOCK_LOG2_RESET;
            blocks_reg     <= BLOCKS_RESET;
            last_alloc_reg <= '0;
            hint_reg       <= '0;
            active_reg     <= '0;
            peak_reg       <= '0;
            valid_reg      <= '0;
            scan_w_reg     <= '0;
            chk_cnt_reg    <= '0;
            rd_word_reg    <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BLOCK_SIZE_LOG2: bs_log2_reg <= cfg_data[LOG2_W-1:0];
                    REG_BLOCKS_IN_USE:   blocks_reg  <= cfg_data;
                    default:             blocks_reg  <= blocks_reg;
                endcase
            end

            if (rd_en)
            begin
                rd_word_reg  <= rd_addr;
                rd_valid_reg <= valid_reg[rd_addr];
            end

            scan_w_reg <= scan_w_next;
            if (cmd.rd_sel == RD_SCAN_START)
                chk_cnt_reg <= '0;
            else if (cmd.rd_sel == RD_SCAN_NEXT)
                chk_cnt_reg <= chk_cnt_reg + WIDX_W'(1);

            if (wr_en)
                valid_reg[rd_word_reg] <= 1'b1;

            active_reg <= active_next;
            peak_reg   <= peak_next;

            if (cmd.commit == COMMIT_ALLOC_SCAN)
                last_alloc_reg <= found_idx;

            if (cmd.clear_hint)
                hint_reg <= '0;
            else if (cmd.commit == COMMIT_FREE)
                hint_reg <= cand_reg;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            len_reg  <= request_length;
            off_reg  <= block_offset;
        end
        if (cmd.setup)
        begin
            cand_reg <= cand_next;
        end
        if (cmd.finish)
        begin
            status_reg <= cmd.status;
            index_reg  <= res_idx;
            aoff_reg   <= alloc_ok ? OFF_W'({{(OFF_W - IDX_W){1'b0}}, res_idx} << eff_log2)
                                   : '0;
        end
    end

    assign status       = status_reg;
    assign block_index  = index_reg;
    assign alloc_offset = aoff_reg;
    assign active_count = active_reg;
    assign peak_count   = peak_reg;

endmodule

// ===== design/bitmap_block_allocator.sv =====
// sequence: a rejected allocate or a bad address ends in the check state; a free
//   ends in the free state and a hinted allocate in the hint probe; a scanning
//   allocate (also after a missed hint) reads map words until a free bit or the last word
// throughput: one item at a time; the scan reads one used-map word per cycle
//   from the single read port of the map ram
// reset: map words read as free, counts, hint and last index cleared,
//   block_size_log2 = 5 and blocks_in_use = 1024; ready right after reset
// results are shown with done, high for one cycle; the receiver cannot stall
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// Fixed-size block allocator over a used-bit map with a last-freed hint,
// a circular word scan and active and peak block counts.
// ----------------------------------------------------------------------------
module bitmap_block_allocator
    import bba_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 func,
    input  logic [LEN_W-1:0]     request_length,
    input  logic [OFF_W-1:0]     block_offset,
    output logic                 done,
    output logic [2:0]           status,
    output logic [IDX_W-1:0]     block_index,
    output logic [OFF_W-1:0]     alloc_offset,
    output logic [CNT_W-1:0]     active_count,
    output logic [CNT_W-1:0]     peak_count,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_sts;

    assign cfg_ready = 1'b1;

    bba_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .dp_sts (dp_sts),
        .cmd    (cmd)
    );

    bba_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_valid & cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .func           (func),
        .request_length (request_length),
        .block_offset   (block_offset),
        .cmd            (cmd),
        .dp_sts         (dp_sts),
        .status         (status),
        .block_index    (block_index),
        .alloc_offset   (alloc_offset),
        .active_count   (active_count),
        .peak_count     (peak_count)
    );

endmodule
